>>> rtl/shortest_path_gateway_table_assert.svh
// assertion macros for the gateway table checker
`ifndef SHORTEST_PATH_GATEWAY_TABLE_ASSERT_SVH
`define SHORTEST_PATH_GATEWAY_TABLE_ASSERT_SVH

// same-cycle implication, off during reset
`define SPGT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define SPGT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/spgt_pkg.sv
// shared types and constants for the gateway table
`default_nettype none

package spgt_pkg;

   // default sizes
   localparam int NUM_VERTICES_DEF = 16;
   localparam int NUM_EDGES_DEF    = 64;
   localparam int WEIGHT_BITS_DEF  = 16;

   // port field widths
   localparam int OP_W   = 2;
   localparam int SLOT_W = 6;
   localparam int VTX_W  = 4;
   localparam int WT_W   = 16;

   // request opcodes
   typedef enum logic [OP_W-1:0] {
      OP_ADD       = 2'd0,
      OP_REMOVE    = 2'd1,
      OP_RECOMPUTE = 2'd2
   } op_type;

   // controller to datapath commands
   typedef struct packed {
      logic add_new;
      logic add_cost;
      logic remove;
      logic init;
      logic scan_clear;
      logic scan_step;
      logic visit;
      logic relax_rd;
      logic chase_start;
      logic chase_rd;
      logic chase_step;
      logic emit;
      logic emit_gw;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic slot_valid;
      logic best_found;
      logic best_inf;
      logic present_here;
      logic pred_here;
      logic chase_more;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/shortest_path_gateway_table.sv
// Add/update or a no-op leaves busy low, so the next word can follow at once.
// Remove/recompute runs an init step, then per settled vertex a vertex scan, a pick,
// an edge scan and a drain; then an emit pass with a predecessor chase per reached vertex.
// Results come one per cycle or slower on rsp_strobe; the receiver cannot stall.
// Synchronous reset clears the edge table, leaves only vertex 0 present.
`default_nettype none

module shortest_path_gateway_table #(
   parameter int NUM_VERTICES = spgt_pkg::NUM_VERTICES_DEF,
   parameter int NUM_EDGES    = spgt_pkg::NUM_EDGES_DEF,
   parameter int WEIGHT_BITS  = spgt_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [spgt_pkg::OP_W-1:0]   req_op,
   input  wire logic [spgt_pkg::SLOT_W-1:0] req_edge_slot,
   input  wire logic [spgt_pkg::VTX_W-1:0]  req_from_vertex,
   input  wire logic [spgt_pkg::VTX_W-1:0]  req_to_vertex,
   input  wire logic [spgt_pkg::WT_W-1:0]   req_weight,
   output logic                             rsp_strobe,
   output logic [spgt_pkg::VTX_W-1:0]       rsp_vertex,
   output logic                             rsp_has_gateway,
   output logic [spgt_pkg::SLOT_W-1:0]      rsp_gateway_edge,
   output logic                             rsp_last
);

   localparam int VW = $clog2(NUM_VERTICES);
   localparam int EW = $clog2(NUM_EDGES);

   spgt_pkg::cmd_type    cmd;
   spgt_pkg::status_type status;
   logic [VW-1:0]        vtx_idx;
   logic [EW-1:0]        edge_idx;

   // sequencer
   spgt_ctrl #(
      .NUM_VERTICES (NUM_VERTICES),
      .NUM_EDGES    (NUM_EDGES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_edge_slot   (req_edge_slot),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .status          (status),
      .cmd             (cmd),
      .vtx_idx         (vtx_idx),
      .edge_idx        (edge_idx)
   );

   // storage and arithmetic
   spgt_datapath #(
      .NUM_VERTICES (NUM_VERTICES),
      .NUM_EDGES    (NUM_EDGES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .vtx_idx          (vtx_idx),
      .edge_idx         (edge_idx),
      .req_edge_slot    (req_edge_slot),
      .req_from_vertex  (req_from_vertex),
      .req_to_vertex    (req_to_vertex),
      .req_weight       (req_weight),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_vertex       (rsp_vertex),
      .rsp_has_gateway  (rsp_has_gateway),
      .rsp_gateway_edge (rsp_gateway_edge),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

>>> rtl/spgt_datapath.sv
// edge table, vertex state, min search, relaxation and gateway output
`default_nettype none

module spgt_datapath #(
   parameter int NUM_VERTICES = spgt_pkg::NUM_VERTICES_DEF,
   parameter int NUM_EDGES    = spgt_pkg::NUM_EDGES_DEF,
   parameter int WEIGHT_BITS  = spgt_pkg::WEIGHT_BITS_DEF,
   localparam int VW = $clog2(NUM_VERTICES),
   localparam int EW = $clog2(NUM_EDGES)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire spgt_pkg::cmd_type          cmd,
   input  wire logic [VW-1:0]              vtx_idx,
   input  wire logic [EW-1:0]              edge_idx,
   input  wire logic [spgt_pkg::SLOT_W-1:0] req_edge_slot,
   input  wire logic [spgt_pkg::VTX_W-1:0]  req_from_vertex,
   input  wire logic [spgt_pkg::VTX_W-1:0]  req_to_vertex,
   input  wire logic [spgt_pkg::WT_W-1:0]   req_weight,
   output spgt_pkg::status_type            status,
   output logic                            rsp_strobe,
   output logic [spgt_pkg::VTX_W-1:0]      rsp_vertex,
   output logic                            rsp_has_gateway,
   output logic [spgt_pkg::SLOT_W-1:0]     rsp_gateway_edge,
   output logic                            rsp_last
);

   localparam int DW = WEIGHT_BITS + VW + 1;

   // edge memories
   logic [VW-1:0]          src_mem  [NUM_EDGES];
   logic [VW-1:0]          tgt_mem  [NUM_EDGES];
   logic [WEIGHT_BITS-1:0] cost_mem [NUM_EDGES];

   logic [NUM_EDGES-1:0]    edge_valid_ff;
   logic [NUM_VERTICES-1:0] present_ff;
   logic [NUM_VERTICES-1:0] visited_ff;
   logic [NUM_VERTICES-1:0] pred_valid_ff;
   logic [EW-1:0]           pred_edge_ff [NUM_VERTICES];
   logic [DW-1:0]           dist_ff      [NUM_VERTICES];

   logic [VW-1:0]          src_q_ff;
   logic [VW-1:0]          tgt_q_ff;
   logic [WEIGHT_BITS-1:0] cost_q_ff;
   logic                   valid_q_ff;
   logic                   relax_q_ff;
   logic [EW-1:0]          eidx_q_ff;

   logic          found_ff;
   logic [VW-1:0] best_ff;
   logic [DW-1:0] best_dist_ff;
   logic [EW-1:0] gate_ff;

   logic                   strobe_ff;
   logic [spgt_pkg::VTX_W-1:0]  vertex_ff;
   logic                   has_ff;
   logic [spgt_pkg::SLOT_W-1:0] gw_ff;
   logic                   last_ff;

   logic [EW-1:0]          wr_addr;
   logic [EW-1:0]          rd_addr;
   logic [VW-1:0]          from_idx;
   logic [VW-1:0]          to_idx;
   logic [WEIGHT_BITS-1:0] new_cost;
   logic [DW-1:0]          tdist;
   logic [DW-1:0]          nd;
   logic                   upd;
   logic                   cand;
   logic [NUM_VERTICES-1:0] above_mask;

   // request decode
   assign wr_addr  = EW'(req_edge_slot);
   assign from_idx = VW'(req_from_vertex);
   assign to_idx   = VW'(req_to_vertex);
   assign new_cost = WEIGHT_BITS'(req_weight);
   assign rd_addr  = cmd.chase_rd ? gate_ff : edge_idx;

   // relaxation of the edge read last cycle
   assign tdist = dist_ff[tgt_q_ff];
   assign nd    = best_dist_ff + DW'(cost_q_ff);
   assign upd   = relax_q_ff && valid_q_ff && (src_q_ff == best_ff) && (nd < tdist);

   // min search candidate
   assign cand = present_ff[vtx_idx] && !visited_ff[vtx_idx] &&
                 (!found_ff || (dist_ff[vtx_idx] < best_dist_ff));

   // vertex indices above the current one
   always_comb begin
      for (int j = 0; j < NUM_VERTICES; j++) begin
         above_mask[j] = (32'(j) > 32'(vtx_idx));
      end
   end

   // status back to the controller
   assign status.slot_valid   = edge_valid_ff[wr_addr];
   assign status.best_found   = found_ff;
   assign status.best_inf     = &best_dist_ff;
   assign status.present_here = present_ff[vtx_idx];
   assign status.pred_here    = pred_valid_ff[vtx_idx];
   assign status.chase_more   = pred_valid_ff[src_q_ff];

   // edge memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.add_new) begin
         src_mem[wr_addr] <= from_idx;
         tgt_mem[wr_addr] <= to_idx;
      end
      if (cmd.add_new || cmd.add_cost) begin
         cost_mem[wr_addr] <= new_cost;
      end
      src_q_ff  <= src_mem[rd_addr];
      tgt_q_ff  <= tgt_mem[rd_addr];
      cost_q_ff <= cost_mem[rd_addr];
      eidx_q_ff <= edge_idx;
   end

   // vertex state, search registers and result word
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_valid_ff <= '0;
         present_ff    <= NUM_VERTICES'(1);
         visited_ff    <= '0;
         pred_valid_ff <= '0;
         for (int v = 0; v < NUM_VERTICES; v++) begin
            pred_edge_ff[v] <= '0;
            dist_ff[v]      <= '1;
         end
         relax_q_ff <= 1'b0;
         valid_q_ff <= 1'b0;
         found_ff   <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         strobe_ff  <= cmd.emit;
         relax_q_ff <= cmd.relax_rd;
         valid_q_ff <= edge_valid_ff[edge_idx];
         // table updates
         if (cmd.add_new) begin
            edge_valid_ff[wr_addr] <= 1'b1;
            present_ff[from_idx]   <= 1'b1;
            present_ff[to_idx]     <= 1'b1;
         end
         if (cmd.remove) begin
            edge_valid_ff[wr_addr] <= 1'b0;
         end
         // start of a recompute
         if (cmd.init) begin
            visited_ff    <= '0;
            pred_valid_ff <= '0;
            for (int v = 0; v < NUM_VERTICES; v++) begin
               pred_edge_ff[v] <= '0;
               dist_ff[v]      <= (v == 0) ? '0 : '1;
            end
         end
         if (cmd.init || cmd.scan_clear) begin
            found_ff <= 1'b0;
         end
         // min search step
         if (cmd.scan_step && cand) begin
            found_ff     <= 1'b1;
            best_ff      <= vtx_idx;
            best_dist_ff <= dist_ff[vtx_idx];
         end
         if (cmd.visit) begin
            visited_ff[best_ff] <= 1'b1;
         end
         // strict decrease wins
         if (upd) begin
            dist_ff[tgt_q_ff]       <= nd;
            pred_edge_ff[tgt_q_ff]  <= eidx_q_ff;
            pred_valid_ff[tgt_q_ff] <= 1'b1;
         end
         // predecessor chase
         if (cmd.chase_start) begin
            gate_ff <= pred_edge_ff[vtx_idx];
         end
         if (cmd.chase_step) begin
            gate_ff <= pred_edge_ff[src_q_ff];
         end
         // result word
         if (cmd.emit) begin
            vertex_ff <= spgt_pkg::VTX_W'(vtx_idx);
            has_ff    <= cmd.emit_gw;
            gw_ff     <= cmd.emit_gw ? spgt_pkg::SLOT_W'(gate_ff) : '0;
            last_ff   <= ~|(present_ff & above_mask);
         end
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_vertex       = vertex_ff;
   assign rsp_has_gateway  = has_ff;
   assign rsp_gateway_edge = gw_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

>>> rtl/spgt_ctrl.sv
// sequencer for table updates, route search and table emission
`default_nettype none

module spgt_ctrl #(
   parameter int NUM_VERTICES = spgt_pkg::NUM_VERTICES_DEF,
   parameter int NUM_EDGES    = spgt_pkg::NUM_EDGES_DEF,
   localparam int VW = $clog2(NUM_VERTICES),
   localparam int EW = $clog2(NUM_EDGES)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [spgt_pkg::OP_W-1:0]   req_op,
   input  wire logic [spgt_pkg::SLOT_W-1:0] req_edge_slot,
   input  wire logic [spgt_pkg::VTX_W-1:0]  req_from_vertex,
   input  wire logic [spgt_pkg::VTX_W-1:0]  req_to_vertex,
   input  wire spgt_pkg::status_type        status,
   output spgt_pkg::cmd_type                cmd,
   output logic [VW-1:0]                    vtx_idx,
   output logic [EW-1:0]                    edge_idx
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_PICK,
      ST_RELAX,
      ST_DRAIN,
      ST_EMIT,
      ST_CH_RD,
      ST_CH_CHK
   } state_type;

   state_type     state_ff, state_in;
   logic [VW-1:0] vi_ff, vi_in;
   logic [EW-1:0] ei_ff, ei_in;
   logic [VW:0]   step_ff, step_in;

   logic slot_ok, from_ok, to_ok, vi_last, ei_last;

   // range checks on the request
   assign slot_ok = 32'(req_edge_slot)   < NUM_EDGES;
   assign from_ok = 32'(req_from_vertex) < NUM_VERTICES;
   assign to_ok   = 32'(req_to_vertex)   < NUM_VERTICES;
   assign vi_last = vi_ff == VW'(NUM_VERTICES - 1);
   assign ei_last = ei_ff == EW'(NUM_EDGES - 1);

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      vi_in    = vi_ff;
      ei_in    = ei_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_op)
                  spgt_pkg::OP_ADD: begin
                     if (slot_ok && from_ok && to_ok) begin
                        if (!status.slot_valid) begin
                           cmd.add_new = 1'b1;
                        end else if (req_from_vertex != '0) begin
                           cmd.add_cost = 1'b1;
                        end
                     end
                  end
                  spgt_pkg::OP_REMOVE: begin
                     if (slot_ok && status.slot_valid) begin
                        cmd.remove = 1'b1;
                        state_in   = ST_INIT;
                     end
                  end
                  spgt_pkg::OP_RECOMPUTE: begin
                     state_in = ST_INIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            vi_in    = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (vi_last) begin
               state_in = ST_PICK;
            end else begin
               vi_in = vi_ff + 1'b1;
            end
         end
         ST_PICK: begin
            if (!status.best_found || status.best_inf) begin
               vi_in    = '0;
               state_in = ST_EMIT;
            end else begin
               cmd.visit = 1'b1;
               ei_in     = '0;
               state_in  = ST_RELAX;
            end
         end
         ST_RELAX: begin
            cmd.relax_rd = 1'b1;
            if (ei_last) begin
               state_in = ST_DRAIN;
            end else begin
               ei_in = ei_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            cmd.scan_clear = 1'b1;
            vi_in          = '0;
            state_in       = ST_SCAN;
         end
         ST_EMIT: begin
            if (status.present_here && status.pred_here) begin
               cmd.chase_start = 1'b1;
               step_in         = '0;
               state_in        = ST_CH_RD;
            end else begin
               cmd.emit = status.present_here;
               if (vi_last) begin
                  state_in = ST_IDLE;
               end else begin
                  vi_in = vi_ff + 1'b1;
               end
            end
         end
         ST_CH_RD: begin
            cmd.chase_rd = 1'b1;
            state_in     = ST_CH_CHK;
         end
         ST_CH_CHK: begin
            if ((step_ff < (VW+1)'(NUM_VERTICES)) && status.chase_more) begin
               cmd.chase_step = 1'b1;
               step_in        = step_ff + 1'b1;
               state_in       = ST_CH_RD;
            end else begin
               cmd.emit    = 1'b1;
               cmd.emit_gw = 1'b1;
               if (vi_last) begin
                  state_in = ST_IDLE;
               end else begin
                  vi_in    = vi_ff + 1'b1;
                  state_in = ST_EMIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vi_ff    <= '0;
         ei_ff    <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         vi_ff    <= vi_in;
         ei_ff    <= ei_in;
         step_ff  <= step_in;
      end
   end

   assign busy     = state_ff != ST_IDLE;
   assign vtx_idx  = vi_ff;
   assign edge_idx = ei_ff;

endmodule

`default_nettype wire

>>> rtl/spgt_checker.sv
// port-level checks for the gateway table, bound to the top level
`default_nettype none

`include "shortest_path_gateway_table_assert.svh"

module spgt_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic [spgt_pkg::OP_W-1:0]   req_op,
   input wire logic                        rsp_strobe,
   input wire logic [spgt_pkg::VTX_W-1:0]  rsp_vertex,
   input wire logic                        rsp_has_gateway,
   input wire logic [spgt_pkg::SLOT_W-1:0] rsp_gateway_edge
);

   logic acc;
   logic acc_add;
   logic acc_recompute;
   logic strobe_nil;
   logic strobe_source;
   assign acc           = start && !busy;
   assign acc_add       = acc && (req_op == spgt_pkg::OP_ADD);
   assign acc_recompute = acc && (req_op == spgt_pkg::OP_RECOMPUTE);
   assign strobe_nil    = rsp_strobe && !rsp_has_gateway;
   assign strobe_source = rsp_strobe && (rsp_vertex == '0);

   // an add word never keeps the block busy
   `SPGT_ASSERT_NEXT(add_stays_idle, clock, reset, acc_add, !busy)
   // a recompute word always starts a search
   `SPGT_ASSERT_NEXT(recompute_goes_busy, clock, reset, acc_recompute, busy)
   // no gateway means a zero edge slot
   `SPGT_ASSERT_NOW(nil_edge_zero, clock, reset, strobe_nil, rsp_gateway_edge == '0)
   // the local vertex never has a gateway
   `SPGT_ASSERT_NOW(source_no_gateway, clock, reset, strobe_source, !rsp_has_gateway)

endmodule

bind shortest_path_gateway_table spgt_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/shortest_path_gateway_table_test.sv
// self-checking testbench for the shortest path gateway table
`timescale 1ns / 100ps

module shortest_path_gateway_table_test;

   localparam int OP_W   = spgt_pkg::OP_W;
   localparam int SLOT_W = spgt_pkg::SLOT_W;
   localparam int VTX_W  = spgt_pkg::VTX_W;
   localparam int WT_W   = spgt_pkg::WT_W;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int NV = spgt_pkg::NUM_VERTICES_DEF;
   localparam int NE = spgt_pkg::NUM_EDGES_DEF;
   localparam int RANDOM_WORDS = 350;

   typedef struct {
      logic [VTX_W-1:0]  vertex;
      logic              has_gw;
      logic [SLOT_W-1:0] gw_edge;
      logic              last;
   } gw_entry_type;

   // one directed row; typed_n < 0 means the predictor decides
   typedef struct {
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] slot;
      logic [VTX_W-1:0]  src;
      logic [VTX_W-1:0]  dst;
      logic [WT_W-1:0]   cost;
      int                typed_n;
      gw_entry_type      typed;
   } route_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [OP_W-1:0]   req_op = spgt_pkg::OP_RECOMPUTE;
   logic [SLOT_W-1:0] req_edge_slot = '0;
   logic [VTX_W-1:0]  req_from_vertex = '0;
   logic [VTX_W-1:0]  req_to_vertex = '0;
   logic [WT_W-1:0]   req_weight = '0;
   logic              rsp_strobe;
   logic [VTX_W-1:0]  rsp_vertex;
   logic              rsp_has_gateway;
   logic [SLOT_W-1:0] rsp_gateway_edge;
   logic              rsp_last;

   shortest_path_gateway_table uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_edge_slot(req_edge_slot),
      .req_from_vertex(req_from_vertex), .req_to_vertex(req_to_vertex),
      .req_weight(req_weight), .rsp_strobe(rsp_strobe), .rsp_vertex(rsp_vertex),
      .rsp_has_gateway(rsp_has_gateway), .rsp_gateway_edge(rsp_gateway_edge),
      .rsp_last(rsp_last)
   );

   always #6 clock = ~clock;

   // mirror of the edge table and vertex set
   bit                edge_used[NE];
   logic [VTX_W-1:0]  edge_from[NE];
   logic [VTX_W-1:0]  edge_to[NE];
   logic [WT_W-1:0]   edge_wt[NE];
   bit                known_vertex[NV];

   gw_entry_type route_batch[$];
   gw_entry_type pending_routes[$];
   int errors = 0;
   int words_sent = 0;
   int routes_seen = 0;
   int tables_built = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   // shortest-path tree from vertex 0, then first hop per known vertex
   function automatic void build_gateway_table();
      longint unsigned path_cost[NV];
      int   pred[NV];
      bit   pred_ok[NV];
      bit   settled[NV];
      int   best, gate, s, n;
      longint unsigned nd;
      gw_entry_type ent;
      route_batch.delete();
      for (int v = 0; v < NV; v++) begin
         path_cost[v] = '1; pred[v] = 0; pred_ok[v] = 0; settled[v] = 0;
      end
      path_cost[0] = 0;
      for (int r = 0; r < NV; r++) begin
         best = NV;
         for (int v = 0; v < NV; v++)
            if (known_vertex[v] && !settled[v] &&
                (best == NV || path_cost[v] < path_cost[best]))
               best = v;
         if (best == NV) break;
         if (path_cost[best] == '1) break;
         settled[best] = 1;
         for (int e = 0; e < NE; e++) begin
            if (edge_used[e] && edge_from[e] == best) begin
               nd = path_cost[best] + edge_wt[e];
               if (nd < path_cost[edge_to[e]]) begin
                  path_cost[edge_to[e]] = nd;
                  pred[edge_to[e]] = e;
                  pred_ok[edge_to[e]] = 1;
               end
            end
         end
      end
      for (int v = 0; v < NV; v++) begin
         if (!known_vertex[v]) continue;
         gate = 0;
         if (pred_ok[v]) begin
            gate = pred[v];
            s = edge_from[gate];
            for (int k = 0; k < NV && pred_ok[s]; k++) begin
               gate = pred[s];
               s = edge_from[gate];
            end
         end
         ent.vertex = VTX_W'(v);
         ent.has_gw = pred_ok[v];
         ent.gw_edge = pred_ok[v] ? SLOT_W'(gate) : '0;
         ent.last = 0;
         route_batch = {route_batch, ent};
      end
      n = route_batch.size();
      if (n > 0) route_batch[n-1].last = 1;
      tables_built++;
   endfunction

   // apply one accepted word to the mirror; leaves its routes in route_batch
   function automatic void apply_route_word(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                            logic [VTX_W-1:0] src, logic [VTX_W-1:0] dst,
                                            logic [WT_W-1:0] cost);
      route_batch.delete();
      case (op)
         spgt_pkg::OP_ADD: begin
            if (!edge_used[slot]) begin
               edge_used[slot] = 1;
               edge_from[slot] = src;
               edge_to[slot] = dst;
               edge_wt[slot] = cost;
               known_vertex[src] = 1;
               known_vertex[dst] = 1;
            end else if (src != 0) begin
               edge_wt[slot] = cost;
            end
         end
         spgt_pkg::OP_REMOVE: begin
            if (edge_used[slot]) begin
               edge_used[slot] = 0;
               build_gateway_table();
            end
         end
         spgt_pkg::OP_RECOMPUTE: build_gateway_table();
         default: ;
      endcase
   endfunction

   // queue the routes of the last word for the checker
   function automatic void expect_batch();
      foreach (route_batch[k]) pending_routes = {pending_routes, route_batch[k]};
   endfunction

   // send one word, waiting a random gap first, then hold until accepted
   task automatic send_word(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                            input logic [VTX_W-1:0] src, input logic [VTX_W-1:0] dst,
                            input logic [WT_W-1:0] cost);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_edge_slot <= slot;
      req_from_vertex <= src;
      req_to_vertex <= dst;
      req_weight <= cost;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         routes_seen++;
         if (pending_routes.size() == 0) begin
            report_mismatch($sformatf("unexpected entry for vertex %0d", rsp_vertex));
         end else begin
            gw_entry_type want;
            want = pending_routes.pop_front();
            if (rsp_vertex !== want.vertex)
               report_mismatch($sformatf("vertex %0d, want %0d", rsp_vertex, want.vertex));
            if (rsp_has_gateway !== want.has_gw)
               report_mismatch($sformatf("vertex %0d has_gateway %b, want %b",
                                         want.vertex, rsp_has_gateway, want.has_gw));
            if (rsp_gateway_edge !== want.gw_edge)
               report_mismatch($sformatf("vertex %0d gateway_edge %0d, want %0d",
                                         want.vertex, rsp_gateway_edge, want.gw_edge));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("vertex %0d last %b, want %b",
                                         want.vertex, rsp_last, want.last));
         end
      end
   end

   // hard stop
   initial begin
      #60_000_000;
      $display("timeout at %0t", $time);
      $display("status: fail");
      $finish;
   end

   // directed rows: typed results only where obvious
   route_row_type directed[$];

   function automatic route_row_type mk(logic [OP_W-1:0] op, int slot, int src, int dst,
                                        int cost, int typed_n = -1);
      route_row_type r;
      r.op = op;
      r.slot = SLOT_W'(slot);
      r.src = VTX_W'(src);
      r.dst = VTX_W'(dst);
      r.cost = WT_W'(cost);
      r.typed_n = typed_n;
      r.typed = '{vertex: '0, has_gw: 1'b0, gw_edge: '0, last: 1'b1};
      return r;
   endfunction

   function automatic void add_row(route_row_type r);
      directed = {directed, r};
   endfunction

   initial begin
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] slot;
      logic [VTX_W-1:0]  src, dst;
      logic [WT_W-1:0]   cost;
      int pick;

      for (int e = 0; e < NE; e++) edge_used[e] = 0;
      for (int v = 0; v < NV; v++) known_vertex[v] = (v == 0);

      // only vertex 0 known after reset, empty slot removes do nothing
      add_row(mk(spgt_pkg::OP_RECOMPUTE, 63, 15, 15, 65535, 1));
      add_row(mk(spgt_pkg::OP_REMOVE, 5, 0, 0, 0, 0));
      add_row(mk(OP_UNUSED, 63, 15, 15, 65535, 0));
      add_row(mk(spgt_pkg::OP_ADD, 0, 0, 1, 1000));
      add_row(mk(spgt_pkg::OP_ADD, 63, 1, 15, 65535));
      add_row(mk(spgt_pkg::OP_ADD, 1, 0, 2, 0));
      add_row(mk(spgt_pkg::OP_ADD, 2, 2, 1, 1000));
      add_row(mk(spgt_pkg::OP_RECOMPUTE, 0, 0, 0, 0));
      // update from the source is dropped, update elsewhere lands
      add_row(mk(spgt_pkg::OP_ADD, 0, 0, 1, 5));
      add_row(mk(spgt_pkg::OP_ADD, 63, 15, 3, 1));
      add_row(mk(spgt_pkg::OP_ADD, 10, 15, 0, 7));
      add_row(mk(spgt_pkg::OP_ADD, 3, 0, 1, 1000));
      add_row(mk(spgt_pkg::OP_ADD, 20, 4, 5, 3));
      add_row(mk(spgt_pkg::OP_ADD, 21, 1, 1, 0));
      add_row(mk(spgt_pkg::OP_RECOMPUTE, 0, 0, 0, 0));
      add_row(mk(spgt_pkg::OP_REMOVE, 1, 0, 0, 0));
      add_row(mk(spgt_pkg::OP_REMOVE, 1, 0, 0, 0, 0));
      add_row(mk(spgt_pkg::OP_ADD, 4, 0, 15, 65535));
      add_row(mk(spgt_pkg::OP_ADD, 5, 15, 4, 65535));
      add_row(mk(spgt_pkg::OP_REMOVE, 0, 0, 0, 0));
      add_row(mk(spgt_pkg::OP_REMOVE, 3, 0, 0, 0));
      add_row(mk(spgt_pkg::OP_RECOMPUTE, 0, 0, 0, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk
      foreach (directed[i]) begin
         send_word(directed[i].op, directed[i].slot, directed[i].src,
                   directed[i].dst, directed[i].cost);
         apply_route_word(directed[i].op, directed[i].slot, directed[i].src,
                          directed[i].dst, directed[i].cost);
         if (directed[i].typed_n >= 0) begin
            route_batch.delete();
            if (directed[i].typed_n > 0) route_batch = {route_batch, directed[i].typed};
         end
         expect_batch();
      end

      // random traffic, mostly live edge churn
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 2) begin
            start <= 1'b0;
            while (pending_routes.size() > 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         slot = SLOT_W'($urandom_range(0, NE - 1));
         src = ($urandom_range(0, 3) == 0) ? '0 : VTX_W'($urandom_range(0, NV - 1));
         dst = VTX_W'($urandom_range(0, NV - 1));
         case ($urandom_range(0, 9))
            0: cost = 16'hffff;
            1: cost = 16'd0;
            2, 3: cost = 16'd1000;
            4: cost = WT_W'($urandom);
            default: cost = WT_W'($urandom_range(1, 200));
         endcase
         if (pick < 55) begin
            op = spgt_pkg::OP_ADD;
         end else if (pick < 80) begin
            op = spgt_pkg::OP_REMOVE;
            // usually aim at a live slot
            if ($urandom_range(0, 9) < 8)
               for (int k = 0; k < NE; k++)
                  if (edge_used[(slot + k) % NE]) begin
                     slot = SLOT_W'((slot + k) % NE);
                     break;
                  end
         end else if (pick < 95) begin
            op = spgt_pkg::OP_RECOMPUTE;
         end else begin
            op = OP_UNUSED;
         end
         send_word(op, slot, src, dst, cost);
         apply_route_word(op, slot, src, dst, cost);
         expect_batch();
      end
      start <= 1'b0;

      // drain
      while (pending_routes.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("sent %0d words, %0d route tables built, %0d entries checked",
               words_sent, tables_built, routes_seen);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> shortest_path_gateway_table.f
+incdir+rtl
rtl/spgt_pkg.sv
rtl/spgt_datapath.sv
rtl/spgt_ctrl.sv
rtl/shortest_path_gateway_table.sv
rtl/spgt_checker.sv
tb/sv/shortest_path_gateway_table_test.sv
